FILE: rtl/asc_pkg.sv
// asc_pkg: request and result types, class codes and the microprogram
// for the aliquot sum classifier; depends on nothing

`default_nettype none

package asc_pkg;

  // payload field widths
  localparam int NUM_IN_W = 16;
  localparam int DSUM_W   = 18;
  localparam int CLASS_W  = 2;

  // divisor_sum saturates here
  localparam logic [DSUM_W-1:0] SUM_MAX = 18'd262143;

  // number class codes
  localparam logic [CLASS_W-1:0] CLASS_PERFECT   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_ABUNDANT  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_DEFICIENT = 2'd2;

  // request and result payloads
  typedef struct packed {
    logic                func;
    logic [NUM_IN_W-1:0] first_number;
    logic [NUM_IN_W-1:0] second_number;
  } in_t;

  typedef struct packed {
    logic [DSUM_W-1:0]  divisor_sum;
    logic [CLASS_W-1:0] number_class;
    logic               amicable;
  } out_t;

  // microcode word layout
  localparam int PC_W   = 4;
  localparam int OP_W   = 4;
  localparam int COND_W = 3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_W-1:0] OP_INIT      = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV_START = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd3;
  localparam logic [OP_W-1:0] OP_ACCUM     = 4'd4;
  localparam logic [OP_W-1:0] OP_SQRT      = 4'd5;
  localparam logic [OP_W-1:0] OP_ZERO      = 4'd6;
  localparam logic [OP_W-1:0] OP_STORE     = 4'd7;
  localparam logic [OP_W-1:0] OP_SEL_B     = 4'd8;
  localparam logic [OP_W-1:0] OP_FINISH    = 4'd9;

  // jump conditions; a hit loads target, otherwise pc advances
  localparam logic [COND_W-1:0] C_NEXT      = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
  localparam logic [COND_W-1:0] C_N_LT2     = 3'd2;
  localparam logic [COND_W-1:0] C_SQ_GE_N   = 3'd3;
  localparam logic [COND_W-1:0] C_DIV_MORE  = 3'd4;
  localparam logic [COND_W-1:0] C_SEL_B     = 3'd5;
  localparam logic [COND_W-1:0] C_SKIP_B    = 3'd6;
  localparam logic [COND_W-1:0] C_OUT_STALL = 3'd7;

  // microprogram addresses
  localparam logic [PC_W-1:0] UA_INIT      = 4'd0;
  localparam logic [PC_W-1:0] UA_TEST      = 4'd1;
  localparam logic [PC_W-1:0] UA_DIV_START = 4'd2;
  localparam logic [PC_W-1:0] UA_DIV_STEP  = 4'd3;
  localparam logic [PC_W-1:0] UA_ACCUM     = 4'd4;
  localparam logic [PC_W-1:0] UA_SQRT      = 4'd5;
  localparam logic [PC_W-1:0] UA_ZERO      = 4'd6;
  localparam logic [PC_W-1:0] UA_STORE     = 4'd7;
  localparam logic [PC_W-1:0] UA_CHECK     = 4'd8;
  localparam logic [PC_W-1:0] UA_SEL_B     = 4'd9;
  localparam logic [PC_W-1:0] UA_FINISH    = 4'd10;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      UA_INIT:      w = '{op: OP_INIT,      cond: C_N_LT2,     target: UA_ZERO};
      UA_TEST:      w = '{op: OP_NOP,       cond: C_SQ_GE_N,   target: UA_SQRT};
      UA_DIV_START: w = '{op: OP_DIV_START, cond: C_NEXT,      target: UA_INIT};
      UA_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  target: UA_DIV_STEP};
      UA_ACCUM:     w = '{op: OP_ACCUM,     cond: C_ALWAYS,    target: UA_TEST};
      UA_SQRT:      w = '{op: OP_SQRT,      cond: C_ALWAYS,    target: UA_STORE};
      UA_ZERO:      w = '{op: OP_ZERO,      cond: C_NEXT,      target: UA_INIT};
      UA_STORE:     w = '{op: OP_STORE,     cond: C_SEL_B,     target: UA_FINISH};
      UA_CHECK:     w = '{op: OP_NOP,       cond: C_SKIP_B,    target: UA_FINISH};
      UA_SEL_B:     w = '{op: OP_SEL_B,     cond: C_ALWAYS,    target: UA_INIT};
      UA_FINISH:    w = '{op: OP_FINISH,    cond: C_OUT_STALL, target: UA_FINISH};
      default:      w = '{op: OP_NOP,       cond: C_ALWAYS,    target: UA_FINISH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aliquot_sum_classifier.sv
// aliquot_sum_classifier: top level, microcoded sequencer with a trial
// division datapath; depends on asc_pkg

`default_nettype none

// Takes a request {func, first_number, second_number} and returns the
// aliquot sum of first_number (saturated to 18 bits), its class (perfect,
// abundant, deficient) and, when func is 1, whether the two numbers form
// an amicable pair. Numbers are cut to NUM_WIDTH bits. A small control
// store steps a datapath through trial divisors d = 2, 3, ... while
// d*d < n; each divisor is tried by the shared restoring divider, which
// makes one quotient bit per cycle. In mode 1 the second number is run
// through the same loop only when the first sum equals it and the
// numbers differ. One request is worked on at a time; a new request is
// taken while the previous result still waits at the output register.

module aliquot_sum_classifier #(
  parameter int NUM_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire asc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output asc_pkg::out_t      out_data
);

  localparam int D_W   = (NUM_WIDTH + 1) / 2 + 1;
  localparam int SQ_W  = NUM_WIDTH + 2;
  localparam int S_W   = NUM_WIDTH + 3;
  localparam int CNT_W = $clog2(NUM_WIDTH);
  localparam int CMP_W = (S_W > asc_pkg::DSUM_W) ? S_W : asc_pkg::DSUM_W;

  // control state
  logic                      busy_r, busy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [asc_pkg::PC_W-1:0]  pc_r, pc_nxt;

  // datapath registers
  logic                      func_r, func_nxt;
  logic                      sel_r, sel_nxt;
  logic [NUM_WIDTH-1:0]      a_r, a_nxt;
  logic [NUM_WIDTH-1:0]      b_r, b_nxt;
  logic [NUM_WIDTH-1:0]      n_r, n_nxt;
  logic [S_W-1:0]            sum_r, sum_nxt;
  logic [S_W-1:0]            sa_r, sa_nxt;
  logic [D_W-1:0]            d_r, d_nxt;
  logic [SQ_W-1:0]           sq_r, sq_nxt;
  logic [D_W-1:0]            rem_r, rem_nxt;
  logic [NUM_WIDTH-1:0]      q_r, q_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  asc_pkg::out_t             out_data_r, out_data_nxt;

  // decode and datapath helpers
  asc_pkg::ucode_t           uc;
  logic                      cond_hit;
  logic                      out_free;
  logic [D_W:0]              rem_sh;
  logic                      fits;
  logic [D_W:0]              rem_sub;
  logic [CMP_W-1:0]          sa_cmp;

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign uc       = asc_pkg::ucode_rom(pc_r);
  assign out_free = !out_valid_r || out_ready;

  // one restoring division step
  assign rem_sh  = {rem_r, q_r[NUM_WIDTH-1]};
  assign fits    = rem_sh >= {1'b0, d_r};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign sa_cmp  = CMP_W'(sa_r);

  // jump condition select
  always_comb begin
    unique case (uc.cond)
      asc_pkg::C_NEXT:      cond_hit = 1'b0;
      asc_pkg::C_ALWAYS:    cond_hit = 1'b1;
      asc_pkg::C_N_LT2:     cond_hit = n_r < NUM_WIDTH'(2);
      asc_pkg::C_SQ_GE_N:   cond_hit = sq_r >= SQ_W'(n_r);
      asc_pkg::C_DIV_MORE:  cond_hit = cnt_r != '0;
      asc_pkg::C_SEL_B:     cond_hit = sel_r;
      asc_pkg::C_SKIP_B:    cond_hit = !(func_r && (a_r != b_r) && (sa_r == S_W'(b_r)));
      asc_pkg::C_OUT_STALL: cond_hit = !out_free;
      default:              cond_hit = 1'b0;
    endcase
  end

  // sequencer and datapath next state
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    pc_nxt        = pc_r;
    func_nxt      = func_r;
    sel_nxt       = sel_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    sa_nxt        = sa_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (busy_r) begin
      unique case (uc.op)
        asc_pkg::OP_NOP: begin
        end
        asc_pkg::OP_INIT: begin
          sum_nxt = S_W'(1);
          d_nxt   = D_W'(2);
          sq_nxt  = SQ_W'(4);
        end
        asc_pkg::OP_DIV_START: begin
          rem_nxt = '0;
          q_nxt   = n_r;
          cnt_nxt = CNT_W'(NUM_WIDTH - 1);
        end
        asc_pkg::OP_DIV_STEP: begin
          rem_nxt = fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
          q_nxt   = {q_r[NUM_WIDTH-2:0], fits};
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        asc_pkg::OP_ACCUM: begin
          // divisor found: add d and its cofactor
          if (rem_r == '0) begin
            sum_nxt = sum_r + S_W'(d_r) + S_W'(q_r);
          end
          d_nxt  = d_r + D_W'(1);
          sq_nxt = sq_r + SQ_W'({d_r, 1'b1});
        end
        asc_pkg::OP_SQRT: begin
          // exact square root counts once
          if (sq_r == SQ_W'(n_r)) begin
            sum_nxt = sum_r + S_W'(d_r);
          end
        end
        asc_pkg::OP_ZERO: begin
          sum_nxt = '0;
        end
        asc_pkg::OP_STORE: begin
          if (!sel_r) begin
            sa_nxt = sum_r;
          end
        end
        asc_pkg::OP_SEL_B: begin
          n_nxt   = b_r;
          sel_nxt = 1'b1;
        end
        asc_pkg::OP_FINISH: begin
          if (out_free) begin
            out_data_nxt.divisor_sum = (sa_cmp > CMP_W'(asc_pkg::SUM_MAX)) ?
                                       asc_pkg::SUM_MAX : asc_pkg::DSUM_W'(sa_cmp);
            if (sa_r == S_W'(a_r)) begin
              out_data_nxt.number_class = asc_pkg::CLASS_PERFECT;
            end else if (sa_r > S_W'(a_r)) begin
              out_data_nxt.number_class = asc_pkg::CLASS_ABUNDANT;
            end else begin
              out_data_nxt.number_class = asc_pkg::CLASS_DEFICIENT;
            end
            out_data_nxt.amicable = sel_r && (sum_r == S_W'(a_r));
            out_valid_nxt = 1'b1;
            busy_nxt      = 1'b0;
          end
        end
        default: begin
        end
      endcase
      pc_nxt = cond_hit ? uc.target : pc_r + asc_pkg::PC_W'(1);
    end

    // new request
    if (in_valid && in_ready) begin
      func_nxt = in_data.func;
      a_nxt    = NUM_WIDTH'(in_data.first_number);
      b_nxt    = NUM_WIDTH'(in_data.second_number);
      n_nxt    = NUM_WIDTH'(in_data.first_number);
      sel_nxt  = 1'b0;
      pc_nxt   = asc_pkg::UA_INIT;
      busy_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= asc_pkg::UA_INIT;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    sel_r      <= sel_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    n_r        <= n_nxt;
    sum_r      <= sum_nxt;
    sa_r       <= sa_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // a taken request starts the program at its first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> busy_r && (pc_r == asc_pkg::UA_INIT))
    else $error("request accepted but sequencer did not start");

  // program counter stays inside the control store
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= asc_pkg::UA_FINISH)
    else $error("program counter outside microprogram");

  // last division step falls through to accumulate
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (pc_r == asc_pkg::UA_DIV_STEP) && (cnt_r == '0)
    |=> pc_r == asc_pkg::UA_ACCUM)
    else $error("divider loop did not exit after last bit");

  // a new result only appears as the sequencer goes idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> !busy_r)
    else $error("result raised while sequencer still busy");

endmodule

`default_nettype wire
